// ===== rtl/tfps_pkg.sv =====
// ----------------------------------------------------------------------------
// tfps_pkg
// shared constants for the pursuit steering block
// ----------------------------------------------------------------------------
package tfps_pkg;

    localparam int TABLE_LEN = 24;
    localparam int VW        = 40;

    localparam logic signed [VW-1:0] GAIN_INV  = VW'(636751);
    localparam logic signed [VW-1:0] HALF_PI   = VW'(1647099);
    localparam logic signed [VW-1:0] PI_Q      = VW'(3294199);
    localparam int                   STEER_LIM = 2000;
    localparam logic [9:0]           BRAKE_CLOSE = 10'd1000;
    localparam logic [9:0]           BRAKE_LOST  = 10'd1;

    localparam logic [7:0] KEY_J_LO = 8'h6a;
    localparam logic [7:0] KEY_J_UP = 8'h4a;
    localparam logic [7:0] KEY_Q_LO = 8'h71;
    localparam logic [7:0] KEY_Q_UP = 8'h51;

    localparam logic [1:0] MODE_NONE     = 2'd0;
    localparam logic [1:0] MODE_JOYSTICK = 2'd1;
    localparam logic [1:0] MODE_SHUTDOWN = 2'd2;

    localparam logic [1:0] REG_MIN_DIST = 2'd0;
    localparam logic [1:0] REG_GAIN     = 2'd1;
    localparam logic [1:0] REG_WBASE    = 2'd2;
    localparam logic [1:0] REG_SCALE    = 2'd3;

    function automatic logic signed [VW-1:0] atan_lut(input logic [4:0] i);
        logic signed [VW-1:0] r;
        unique case (i)
            5'd0: r = VW'(823550);
            5'd1: r = VW'(486170);
            5'd2: r = VW'(256879);
            5'd3: r = VW'(130396);
            5'd4: r = VW'(65451);
            5'd5: r = VW'(32757);
            5'd6: r = VW'(16383);
            5'd7: r = VW'(8192);
            5'd8: r = VW'(4096);
            5'd9: r = VW'(2048);
            5'd10: r = VW'(1024);
            5'd11: r = VW'(512);
            5'd12: r = VW'(256);
            5'd13: r = VW'(128);
            5'd14: r = VW'(64);
            5'd15: r = VW'(32);
            5'd16: r = VW'(16);
            5'd17: r = VW'(8);
            5'd18: r = VW'(4);
            5'd19: r = VW'(2);
            5'd20: r = VW'(1);
            default: r = '0;
        endcase
        return r;
    endfunction

endpackage

// ===== rtl/tfps_cordic.sv =====
// ----------------------------------------------------------------------------
// tfps_cordic
// shared cordic unit, one micro-rotation per cycle, rotation or vectoring
// ----------------------------------------------------------------------------
module tfps_cordic
    import tfps_pkg::*;
#(
    parameter int CORDIC_STEPS = 16
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic                 vectoring,
    input  logic signed [VW-1:0] x_in,
    input  logic signed [VW-1:0] y_in,
    input  logic signed [VW-1:0] z_in,
    output logic                 done,
    output logic signed [VW-1:0] y_out,
    output logic signed [VW-1:0] z_out
);

    localparam int STEPS = (CORDIC_STEPS < TABLE_LEN) ? CORDIC_STEPS : TABLE_LEN;

    logic                 busy_reg;
    logic                 vec_reg;
    logic [4:0]           step_reg;
    logic signed [VW-1:0] x_reg, y_reg, z_reg;
    logic                 dir_neg;
    logic signed [VW-1:0] dx, dy, at;

    assign dir_neg = vec_reg ? ~y_reg[VW-1] : z_reg[VW-1];
    assign dx = y_reg >>> step_reg;
    assign dy = x_reg >>> step_reg;
    assign at = atan_lut(step_reg);
    assign y_out = y_reg;
    assign z_out = z_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done     <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            done <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                vec_reg  <= vectoring;
                step_reg <= '0;
                x_reg    <= x_in;
                y_reg    <= y_in;
                z_reg    <= z_in;
            end
            else if (busy_reg)
            begin
                // vectoring: y>=0 rotates down
                if (dir_neg)
                begin
                    x_reg <= x_reg + dx;
                    y_reg <= y_reg - dy;
                    z_reg <= z_reg + at;
                end
                else
                begin
                    x_reg <= x_reg - dx;
                    y_reg <= y_reg + dy;
                    z_reg <= z_reg - at;
                end
                if (vec_reg)
                begin
                    if (dir_neg)
                        z_reg <= z_reg + at;
                    else
                        z_reg <= z_reg - at;
                end
                if (step_reg == 5'(STEPS - 1))
                begin
                    busy_reg <= 1'b0;
                    done     <= 1'b1;
                end
                step_reg <= step_reg + 5'd1;
            end
        end
    end

endmodule

// ===== rtl/target_follow_pursuit_steer_top.sv =====
// ----------------------------------------------------------------------------
// target_follow_pursuit_steer_top
// pure pursuit steering, brake and speed from one tracking report
// ----------------------------------------------------------------------------
// channel  dir  fields
// s_axis   in   tdata: target_distance[15:0] target_bearing[31:16] key_code[39:32]
//               tuser: target_valid
// m_axis   out  tdata: brake_level[9:0] speed_level[25:10]
//               steer_position[37:26] mode_request[39:38]
// cfg      in   cfg_index selects register, cfg_data value
// a tracked request runs the shared cordic unit once for the sine and once for
// the arctangent, the second run skipped when wheelbase times distance is zero;
// a lost-target request bypasses the cordic unit
// reset clears last steer and registers to defaults
// s_axis_tready is low while a request is in work or its result waits
// ----------------------------------------------------------------------------
module target_follow_pursuit_steer_top
    import tfps_pkg::*;
#(
    parameter int CORDIC_STEPS = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,   // target_distance, target_bearing, key_code
    input  logic        s_axis_tuser,   // target_valid
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,   // brake_level, speed_level, steer_position, mode_request
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    typedef enum logic [2:0] {S_IDLE, S_SIN, S_SWAIT, S_ATAN, S_AWAIT, S_MUL, S_OUT} state_t;

    state_t state_reg;
    logic [15:0] min_reg, gain_reg, wb_reg;
    logic [11:0] scale_reg;
    logic signed [11:0] last_reg;
    logic        valid_reg;
    logic [15:0] dist_reg;
    logic signed [VW-1:0] ang_reg, sin_reg, theta_reg;
    logic [31:0] div_reg;
    logic [9:0]  brake_reg;
    logic [15:0] speed_reg;
    logic [1:0]  mode_reg;
    logic        c_start, c_vec, c_done;
    logic signed [VW-1:0] c_x, c_y, c_z, c_yo, c_zo;
    logic signed [VW-1:0] bang, ang_fold;
    logic [31:0] spd_prod;
    logic signed [VW+13:0] p_full;
    logic signed [VW+13:0] p_sh;
    logic signed [11:0] p_clip;
    logic [1:0] mode_c;

    assign cfg_ready = 1'b1;
    assign s_axis_tready = (state_reg == S_IDLE) && !m_axis_tvalid;

    assign bang = VW'($signed(s_axis_tdata[31:16])) <<< 7;
    always_comb
    begin
        if (bang > HALF_PI)
            ang_fold = PI_Q - bang;
        else if (bang < -HALF_PI)
            ang_fold = -PI_Q - bang;
        else
            ang_fold = bang;
    end

    always_comb
    begin
        priority if (s_axis_tdata[39:32] == KEY_J_LO || s_axis_tdata[39:32] == KEY_J_UP)
            mode_c = MODE_JOYSTICK;
        else if (s_axis_tdata[39:32] == KEY_Q_LO || s_axis_tdata[39:32] == KEY_Q_UP)
            mode_c = MODE_SHUTDOWN;
        else
            mode_c = MODE_NONE;
    end

    assign c_start = (state_reg == S_SIN) || (state_reg == S_ATAN);
    assign c_vec = (state_reg == S_ATAN);
    assign c_x = (state_reg == S_ATAN) ? $signed({4'd0, div_reg, 4'd0}) : GAIN_INV;
    assign c_y = (state_reg == S_ATAN) ? (sin_reg <<< 1) : '0;
    assign c_z = (state_reg == S_ATAN) ? '0 : ang_reg;

    tfps_cordic #(.CORDIC_STEPS(CORDIC_STEPS)) u_cordic (
        .clk(clk), .rst_n(rst_n), .start(c_start), .vectoring(c_vec),
        .x_in(c_x), .y_in(c_y), .z_in(c_z), .done(c_done),
        .y_out(c_yo), .z_out(c_zo)
    );

    assign spd_prod = 32'(dist_reg - min_reg) * 32'(gain_reg);
    assign p_full = $signed({2'b0, scale_reg}) * theta_reg + (VW+14)'(524288);
    assign p_sh = p_full >>> 20;
    assign p_clip = (p_sh > STEER_LIM) ? 12'sd2000 :
                    (p_sh < -STEER_LIM) ? -12'sd2000 : p_sh[11:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            m_axis_tvalid <= 1'b0;
            min_reg       <= 16'd512;
            gain_reg      <= 16'd256;
            wb_reg        <= 16'd512;
            scale_reg     <= 12'd1273;
            last_reg      <= '0;
        end
        else
        begin
            if (cfg_valid)
            begin
                unique case (cfg_index)
                    REG_MIN_DIST: min_reg   <= cfg_data;
                    REG_GAIN:     gain_reg  <= cfg_data;
                    REG_WBASE:    wb_reg    <= cfg_data;
                    REG_SCALE:    scale_reg <= cfg_data[11:0];
                endcase
            end
            if (m_axis_tvalid && m_axis_tready)
                m_axis_tvalid <= 1'b0;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (s_axis_tvalid && s_axis_tready)
                    begin
                        valid_reg <= s_axis_tuser;
                        dist_reg  <= s_axis_tdata[15:0];
                        mode_reg  <= mode_c;
                        ang_reg   <= ang_fold;
                        div_reg   <= 32'(wb_reg) * 32'(s_axis_tdata[15:0]);
                        state_reg <= s_axis_tuser ? S_SIN : S_OUT;
                    end
                end
                S_SIN: state_reg <= S_SWAIT;
                S_SWAIT:
                begin
                    if (c_done)
                    begin
                        sin_reg <= c_yo;
                        if (div_reg == '0)
                        begin
                            theta_reg <= (c_yo > 0) ? HALF_PI :
                                         (c_yo < 0) ? -HALF_PI : '0;
                            state_reg <= S_MUL;
                        end
                        else
                            state_reg <= S_ATAN;
                    end
                    if (dist_reg < min_reg)
                    begin
                        brake_reg <= BRAKE_CLOSE;
                        speed_reg <= '0;
                    end
                    else
                    begin
                        brake_reg <= '0;
                        speed_reg <= (spd_prod[31:24] != 8'd0) ? 16'hffff : spd_prod[23:8];
                    end
                end
                S_ATAN: state_reg <= S_AWAIT;
                S_AWAIT:
                begin
                    if (c_done)
                    begin
                        theta_reg <= c_zo;
                        state_reg <= S_MUL;
                    end
                end
                S_MUL:
                begin
                    last_reg  <= p_clip;
                    state_reg <= S_OUT;
                end
                S_OUT:
                begin
                    if (!valid_reg)
                    begin
                        brake_reg <= BRAKE_LOST;
                        speed_reg <= '0;
                    end
                    m_axis_tvalid <= 1'b1;
                    state_reg     <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign m_axis_tdata = {mode_reg, last_reg, speed_reg, brake_reg};

    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE) |-> !s_axis_tready)
        else $error("accept while busy");
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result lost");
    a_steer_lim: assert property (@(posedge clk) disable iff (!rst_n)
        (last_reg <= 12'sd2000) && (last_reg >= -12'sd2000))
        else $error("steer out of range");

endmodule

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pursuit steering testbench
// drives tracking reports with random gaps and back pressure, predicts brake,
// speed, steering and mode request per report and checks every result in order
// ----------------------------------------------------------------------------
module testbench;
    import tfps_pkg::*;

    localparam int STEPS      = 16;
    localparam int STALL_MAX  = 4000;

    typedef struct packed {
        logic        valid;
        logic [15:0] distance;
        logic [15:0] bearing;
        logic [7:0]  key;
    } report_t;

    typedef struct packed {
        logic [1:0]  mode;
        logic [11:0] steer;
        logic [15:0] speed;
        logic [9:0]  brake;
    } command_t;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [39:0] s_axis_tdata;
    logic        s_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [39:0] m_axis_tdata;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [1:0]  cfg_index;
    logic [15:0] cfg_data;

    report_t  pending_reports[$];
    command_t expected_commands[$];

    logic [15:0] min_dist_reg;
    logic [15:0] gain_reg;
    logic [15:0] wbase_reg;
    logic [11:0] scale_reg;
    logic signed [11:0] held_steer;

    int send_idle_pct;
    int recv_idle_pct;
    int stall_cycles;
    bit failed;
    bit in_taken;

    target_follow_pursuit_steer_top #(.CORDIC_STEPS(STEPS)) u_top (.*);

    initial clk = 1'b0;
    always #2 clk = ~clk;

    function automatic logic signed [63:0] floor_shift(logic signed [63:0] v, int s);
        return v >>> s;
    endfunction

    function automatic logic signed [63:0] cordic_sine(logic signed [63:0] ang);
        logic signed [63:0] x;
        logic signed [63:0] y;
        logic signed [63:0] z;
        logic signed [63:0] dx;
        logic signed [63:0] dy;
        x = 64'(GAIN_INV);
        y = 0;
        z = ang;
        for (int i = 0; i < STEPS && i < TABLE_LEN; i++)
        begin
            dx = floor_shift(y, i);
            dy = floor_shift(x, i);
            if (z >= 0)
            begin
                x -= dx; y += dy; z -= 64'(atan_lut(5'(i)));
            end
            else
            begin
                x += dx; y -= dy; z += 64'(atan_lut(5'(i)));
            end
        end
        return y;
    endfunction

    function automatic logic signed [63:0] cordic_angle(logic signed [63:0] y,
                                                       logic signed [63:0] x);
        logic signed [63:0] z;
        logic signed [63:0] dx;
        logic signed [63:0] dy;
        z = 0;
        for (int i = 0; i < STEPS && i < TABLE_LEN; i++)
        begin
            dx = floor_shift(y, i);
            dy = floor_shift(x, i);
            if (y < 0)
            begin
                x -= dx; y += dy; z -= 64'(atan_lut(5'(i)));
            end
            else
            begin
                x += dx; y -= dy; z += 64'(atan_lut(5'(i)));
            end
        end
        return z;
    endfunction

    function automatic command_t steer_command(report_t r);
        command_t c;
        logic signed [63:0] ang;
        logic signed [63:0] s;
        logic signed [63:0] theta;
        logic signed [63:0] p;
        logic [63:0] v;
        logic [63:0] dv;
        c.brake = BRAKE_LOST;
        c.speed = '0;
        c.mode = MODE_NONE;
        if (r.valid)
        begin
            if (r.distance < min_dist_reg)
                c.brake = BRAKE_CLOSE;
            else
            begin
                v = (64'(r.distance - min_dist_reg) * 64'(gain_reg)) >> 8;
                c.brake = '0;
                c.speed = (v > 65535) ? 16'hffff : v[15:0];
            end
            ang = 64'(signed'(r.bearing)) * 128;
            if (ang > 64'(HALF_PI))
                ang = 64'(PI_Q) - ang;
            else if (ang < -64'(HALF_PI))
                ang = -64'(PI_Q) - ang;
            s = cordic_sine(ang);
            dv = 64'(wbase_reg) * 64'(r.distance);
            if (dv == 0)
                theta = (s > 0) ? 64'(HALF_PI) : ((s < 0) ? -64'(HALF_PI) : 64'sd0);
            else
                theta = cordic_angle(2 * s, signed'(dv * 16));
            p = floor_shift(64'(scale_reg) * theta + 64'sd524288, 20);
            if (p > STEER_LIM)
                p = STEER_LIM;
            if (p < -STEER_LIM)
                p = -STEER_LIM;
            held_steer = p[11:0];
        end
        c.steer = held_steer;
        if (r.key == KEY_J_LO || r.key == KEY_J_UP)
            c.mode = MODE_JOYSTICK;
        else if (r.key == KEY_Q_LO || r.key == KEY_Q_UP)
            c.mode = MODE_SHUTDOWN;
        return c;
    endfunction

    // input accept and prediction
    always @(posedge clk)
    begin
        report_t r;
        if (rst_n && s_axis_tvalid && s_axis_tready)
        begin
            r = pending_reports.pop_front();
            expected_commands = {expected_commands, steer_command(r)};
            in_taken = 1'b1;
        end
    end

    // driver
    always @(negedge clk)
    begin
        report_t r;
        if (rst_n)
        begin
            if (!(s_axis_tvalid && !in_taken))
            begin
                if (pending_reports.size() > 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    r = pending_reports[0];
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= {r.key, r.bearing, r.distance};
                    s_axis_tuser  <= r.valid;
                end
                else
                    s_axis_tvalid <= 1'b0;
            end
            in_taken = 1'b0;
            m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // monitor
    always @(posedge clk)
    begin
        command_t got;
        command_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got = m_axis_tdata;
            if (expected_commands.size() == 0)
            begin
                $display("%0t unexpected result %h", $time, got);
                failed = 1'b1;
            end
            else
            begin
                want = expected_commands.pop_front();
                if (got.brake !== want.brake)
                begin
                    $display("%0t brake exp %0d got %0d", $time, want.brake, got.brake);
                    failed = 1'b1;
                end
                if (got.speed !== want.speed)
                begin
                    $display("%0t speed exp %0d got %0d", $time, want.speed, got.speed);
                    failed = 1'b1;
                end
                if (got.steer !== want.steer)
                begin
                    $display("%0t steer exp %0d got %0d", $time,
                             signed'(want.steer), signed'(got.steer));
                    failed = 1'b1;
                end
                if (got.mode !== want.mode)
                begin
                    $display("%0t mode exp %0d got %0d", $time, want.mode, got.mode);
                    failed = 1'b1;
                end
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
            || (cfg_valid && cfg_ready) || !rst_n)
            stall_cycles <= 0;
        else
        begin
            stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= STALL_MAX)
            begin
                $display("Simulation FAILED");
                $finish;
            end
        end
    end

    task automatic write_reg(logic [1:0] idx, logic [15:0] val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge clk); while (!cfg_ready);
        case (idx)
            REG_MIN_DIST: min_dist_reg = val;
            REG_GAIN:     gain_reg = val;
            REG_WBASE:    wbase_reg = val;
            default:      scale_reg = val[11:0];
        endcase
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic drain;
        wait (pending_reports.size() == 0 && !s_axis_tvalid);
        wait (expected_commands.size() == 0);
        repeat (2 * STEPS + 20) @(posedge clk);
    endtask

    task automatic add_report(logic v, logic [15:0] d, logic [15:0] b, logic [7:0] k);
        report_t r;
        r = {v, d, b, k};
        pending_reports = {pending_reports, r};
    endtask

    task automatic add_random(int n);
        int sel;
        for (int i = 0; i < n; i++)
        begin
            sel = $urandom_range(9);
            add_report($urandom_range(9) != 0,
                       (sel < 3) ? 16'($urandom_range(2047)) : 16'($urandom),
                       (sel == 9) ? 16'($urandom)
                                  : 16'($signed($urandom_range(51472)) - 25736),
                       ($urandom_range(3) == 0) ? 8'($urandom) :
                       ($urandom_range(1) ? 8'h00 : 8'($urandom_range(3) == 0 ? KEY_J_LO :
                       $urandom_range(2) == 0 ? KEY_J_UP : $urandom_range(1) ? KEY_Q_LO
                       : KEY_Q_UP)));
        end
    endtask

    initial
    begin
        min_dist_reg = 16'd512;
        gain_reg = 16'd256;
        wbase_reg = 16'd512;
        scale_reg = 12'd1273;
        held_steer = '0;
        failed = 1'b0;
        in_taken = 1'b0;
        stall_cycles = 0;
        send_idle_pct = 24;
        recv_idle_pct = 69;
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = 1'b0;
        m_axis_tready = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = REG_MIN_DIST;
        cfg_data = '0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: reset settings, extremes, keys, lost target, reflection
        add_report(1'b0, 16'h0000, 16'h0000, 8'h00);
        add_report(1'b1, 16'd512, 16'd4000, KEY_J_LO);
        add_report(1'b1, 16'd100, 16'hc000, KEY_J_UP);
        add_report(1'b0, 16'hffff, 16'h7fff, KEY_Q_LO);
        add_report(1'b1, 16'hffff, 16'd25736, KEY_Q_UP);
        add_report(1'b1, 16'd1000, 16'h8000, 8'hff);
        add_report(1'b1, 16'd1000, 16'h7fff, 8'h00);
        add_report(1'b1, 16'd0, 16'd5000, 8'h00);
        add_report(1'b1, 16'd0, 16'hec78, 8'h00);
        add_report(1'b1, 16'd0, 16'd0, 8'h00);
        add_report(1'b1, 16'd600, -16'sd25736, 8'h00);
        add_report(1'b1, 16'd600, 16'd20000, 8'h00);
        add_report(1'b0, 16'd600, 16'd20000, 8'h00);
        drain();

        write_reg(REG_MIN_DIST, 16'd0);
        write_reg(REG_GAIN, 16'hffff);
        write_reg(REG_WBASE, 16'd1);
        write_reg(REG_SCALE, 16'hffff);
        add_report(1'b1, 16'hffff, 16'd12868, 8'h00);
        add_report(1'b1, 16'd1, -16'sd12868, 8'h00);
        add_report(1'b1, 16'd0, 16'd100, 8'h00);
        add_random(250);
        drain();

        write_reg(REG_MIN_DIST, 16'hffff);
        write_reg(REG_GAIN, 16'd0);
        write_reg(REG_WBASE, 16'hffff);
        write_reg(REG_SCALE, 16'd0);
        add_random(150);
        drain();

        send_idle_pct = 69;
        recv_idle_pct = 24;
        write_reg(REG_MIN_DIST, 16'($urandom_range(4096)));
        write_reg(REG_GAIN, 16'($urandom));
        write_reg(REG_WBASE, 16'($urandom_range(65535, 1)));
        write_reg(REG_SCALE, 16'($urandom_range(4095)));
        add_random(350);
        drain();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_reg(REG_MIN_DIST, 16'd512);
        write_reg(REG_GAIN, 16'd256);
        write_reg(REG_WBASE, 16'd512);
        write_reg(REG_SCALE, 16'd1273);
        add_random(380);
        drain();

        if (!failed)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end
endmodule

// ===== sim.f =====
rtl/tfps_pkg.sv
rtl/tfps_cordic.sv
rtl/target_follow_pursuit_steer_top.sv
tb/sv/testbench.sv
